### rtl/core/dmac_pkg.sv
package dmac_pkg;

   // step kinds carried in the cmd field
   typedef enum logic [1:0] {
      CMD_REG_WRITE  = 2'd0,
      CMD_REG_READ   = 2'd1,
      CMD_PAGE_WRITE = 2'd2,
      CMD_XFER       = 2'd3
   } cmd_type;

   // register numbers above the channel address/count pairs, and last page
   localparam logic [4:0] REG_COMMAND      = 5'd8;
   localparam logic [4:0] REG_REQUEST      = 5'd9;
   localparam logic [4:0] REG_MASK_BIT     = 5'd10;
   localparam logic [4:0] REG_MODE         = 5'd11;
   localparam logic [4:0] REG_CLEAR_FF     = 5'd12;
   localparam logic [4:0] REG_MASTER_CLEAR = 5'd13;
   localparam logic [4:0] REG_MASK_ALL     = 5'd15;
   localparam logic [4:0] REG_PAGE_LAST    = 5'd3;

   // transfer type, mode bits 3:2
   localparam logic [1:0] XFER_VERIFY = 2'd0;
   localparam logic [1:0] XFER_WRITE  = 2'd1;
   localparam logic [1:0] XFER_READ   = 2'd2;

   localparam int MODE_DEC_BIT = 5;

   localparam logic [15:0] COUNT_RESET = 16'hFFFF;

   // per-channel update strobes, all qualified by a committed beat
   typedef struct packed {
      logic       wr_addr;
      logic       wr_count;
      logic       wr_mode;
      logic       wr_page;
      logic       step;
      logic       clear;
      logic       hi;
      logic [7:0] data;
   } chan_op_type;

   // per-channel view seen by the register/step logic
   typedef struct packed {
      logic [7:0]  mode;
      logic [15:0] cur_addr;
      logic [15:0] cur_count;
      logic [31:0] xfer_addr;
      logic        count_zero;
   } chan_stat_type;

   function automatic logic mode_moves(input logic [7:0] mode);
      return (mode[3:2] == XFER_WRITE) || (mode[3:2] == XFER_READ);
   endfunction

endpackage

### rtl/core/dma_controller_registers.sv
// An accepted beat passes the input register, then the response register.
// Throughput: one beat per cycle while the response side is not stalled;
// the request side and the response side each have one of the two registers, and each beat's decode,
// channel address add and state update fit between them.
// Reset (synchronous, active high): empties both registers, clears all
// controller state, sets every current count to 0xFFFF and mem_base to 0.
module dma_controller_registers #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_reg_req,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [31:0] rsp_mem_address,
   output logic        rsp_xfer_valid,
   output logic        rsp_to_memory,
   output logic        rsp_last,
   output logic        rsp_refused,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   // ---------------------------------------------------------------------
   // Configuration: mem_base; not enforced by the block, the user must write it only while the block is quiet
   // ---------------------------------------------------------------------
   logic [31:0] mem_base_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         mem_base_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Input register. The response side frees up whenever its register is empty
   // or being drained, so a new beat can enter every cycle unless it is stalled.
   // ---------------------------------------------------------------------
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_cmd_ff;
   logic [4:0] in_reg_ff;
   logic [1:0] in_chan_ff;
   logic [7:0] in_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic fire;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cmd_ff  <= req_cmd;
         in_reg_ff  <= req_reg_req;
         in_chan_ff <= req_channel;
         in_data_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------------
   // Decode
   // ---------------------------------------------------------------------
   dmac_pkg::cmd_type cmd;
   logic is_wr, is_rd, is_page, is_xfer;
   logic chan_reg;          // registers 0..7: channel address/count pairs

   assign cmd      = dmac_pkg::cmd_type'(in_cmd_ff);
   assign is_wr    = (cmd == dmac_pkg::CMD_REG_WRITE);
   assign is_rd    = (cmd == dmac_pkg::CMD_REG_READ);
   assign is_page  = (cmd == dmac_pkg::CMD_PAGE_WRITE);
   assign is_xfer  = (cmd == dmac_pkg::CMD_XFER);
   assign chan_reg = (in_reg_ff[4:3] == 2'b00);

   // global controller state
   logic       ff_ff,      ff_in;       // byte flip-flop
   logic [7:0] command_ff, command_in;
   logic [7:0] request_ff, request_in;
   logic [3:0] mask_ff,    mask_in;
   logic [7:0] status_ff,  status_in;

   // lane hits: address/count pair, transfer/page channel, mode channel
   logic [NUM_CHANNELS-1:0] pair_hit;
   logic [NUM_CHANNELS-1:0] chan_hit;
   logic [NUM_CHANNELS-1:0] mode_hit;
   logic pair_ok, chan_ok;
   logic master_clear;
   logic masked;

   dmac_pkg::chan_op_type   lane_op   [NUM_CHANNELS];
   dmac_pkg::chan_stat_type lane_stat [NUM_CHANNELS];
   dmac_pkg::chan_stat_type pair_stat;
   dmac_pkg::chan_stat_type chan_stat;

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         pair_hit[i] = (32'(in_reg_ff[2:1]) == 32'(i));
         chan_hit[i] = (32'(in_chan_ff) == 32'(i));
         mode_hit[i] = (32'(in_data_ff[1:0]) == 32'(i));
      end
   end

   assign pair_ok      = |pair_hit;
   assign chan_ok      = |chan_hit;
   assign master_clear = fire && is_wr && (in_reg_ff == dmac_pkg::REG_MASTER_CLEAR);
   assign masked       = mask_ff[in_chan_ff];

   // lane selection muxes
   always_comb begin
      pair_stat = '0;
      chan_stat = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (pair_hit[i]) begin
            pair_stat = lane_stat[i];
         end
         if (chan_hit[i]) begin
            chan_stat = lane_stat[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Channel lanes
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      always_comb begin
         lane_op[g].wr_addr  = fire && is_wr && chan_reg && pair_hit[g] && !in_reg_ff[0];
         lane_op[g].wr_count = fire && is_wr && chan_reg && pair_hit[g] && in_reg_ff[0];
         lane_op[g].wr_mode  = fire && is_wr && (in_reg_ff == dmac_pkg::REG_MODE)
                               && mode_hit[g];
         lane_op[g].wr_page  = fire && is_page && (in_reg_ff <= dmac_pkg::REG_PAGE_LAST)
                               && chan_hit[g];
         lane_op[g].step     = fire && is_xfer && chan_hit[g] && !masked;
         lane_op[g].clear    = master_clear;
         lane_op[g].hi       = ff_ff;
         lane_op[g].data     = in_data_ff;
      end

      dmac_channel u_channel (
         .clock    (clock),
         .reset    (reset),
         .mem_base (mem_base_ff),
         .op       (lane_op[g]),
         .stat     (lane_stat[g])
      );
   end

   // ---------------------------------------------------------------------
   // Step result
   // ---------------------------------------------------------------------
   logic        refused;
   logic        moving;
   logic        end_chan;   // terminal count or non-moving type ends the channel
   logic [15:0] rd_word;
   logic [7:0]  read_data;

   assign refused  = is_xfer && (!chan_ok || masked);
   assign moving   = is_xfer && !refused && dmac_pkg::mode_moves(chan_stat.mode);
   assign end_chan = is_xfer && !refused
                     && (!dmac_pkg::mode_moves(chan_stat.mode) || chan_stat.count_zero);

   assign rd_word = in_reg_ff[0] ? pair_stat.cur_count : pair_stat.cur_addr;

   always_comb begin
      read_data = '0;
      if (is_rd) begin
         if (chan_reg) begin
            if (pair_ok) begin
               read_data = ff_ff ? rd_word[15:8] : rd_word[7:0];
            end
         end else if (in_reg_ff == dmac_pkg::REG_COMMAND) begin
            read_data = status_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Global register updates; a master clear or a channel end can touch more than one of them
   // ---------------------------------------------------------------------
   always_comb begin
      ff_in      = ff_ff;
      command_in = command_ff;
      request_in = request_ff;
      mask_in    = mask_ff;
      status_in  = status_ff;
      if (fire) begin
         if ((is_wr || is_rd) && chan_reg && pair_ok) begin
            ff_in = !ff_ff;
         end
         if (is_wr) begin
            priority if (in_reg_ff == dmac_pkg::REG_COMMAND) begin
               command_in = in_data_ff;
            end else if (in_reg_ff == dmac_pkg::REG_REQUEST) begin
               request_in = in_data_ff;
            end else if (in_reg_ff == dmac_pkg::REG_MASK_BIT) begin
               mask_in[in_data_ff[1:0]] = in_data_ff[2];
            end else if (in_reg_ff == dmac_pkg::REG_CLEAR_FF) begin
               ff_in = 1'b0;
            end else if (in_reg_ff == dmac_pkg::REG_MASTER_CLEAR) begin
               ff_in      = 1'b0;
               command_in = '0;
               status_in  = '0;
            end else if (in_reg_ff == dmac_pkg::REG_MASK_ALL) begin
               mask_in = in_data_ff[3:0];
            end
         end
         // status read clears status
         if (is_rd && (in_reg_ff == dmac_pkg::REG_COMMAND)) begin
            status_in = '0;
         end
         if (end_chan) begin
            mask_in[in_chan_ff]   = 1'b1;
            status_in[in_chan_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_ff      <= 1'b0;
         command_ff <= '0;
         request_ff <= '0;
         mask_ff    <= '0;
         status_ff  <= '0;
      end else begin
         ff_ff      <= ff_in;
         command_ff <= command_in;
         request_ff <= request_in;
         mask_ff    <= mask_in;
         status_ff  <= status_in;
      end
   end

   // command and request registers are held for software; nothing here
   // acts on them, so only writes and, for command, the master clear change them

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic [7:0]  rsp_read_data_ff;
   logic [31:0] rsp_mem_address_ff;
   logic        rsp_xfer_valid_ff;
   logic        rsp_to_memory_ff;
   logic        rsp_last_ff;
   logic        rsp_refused_ff;

   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_read_data_ff   <= read_data;
         rsp_mem_address_ff <= moving ? chan_stat.xfer_addr : 32'd0;
         rsp_xfer_valid_ff  <= moving;
         rsp_to_memory_ff   <= moving && (chan_stat.mode[3:2] == dmac_pkg::XFER_WRITE);
         rsp_last_ff        <= end_chan;
         rsp_refused_ff     <= refused;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_mem_address = rsp_mem_address_ff;
   assign rsp_xfer_valid  = rsp_xfer_valid_ff;
   assign rsp_to_memory   = rsp_to_memory_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_refused     = rsp_refused_ff;

endmodule

### rtl/core/dmac_channel.sv
module dmac_channel (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             mem_base,
   input  dmac_pkg::chan_op_type   op,
   output dmac_pkg::chan_stat_type stat
);

   logic [7:0]  mode_ff,       mode_in;
   logic [7:0]  page_ff,       page_in;
   logic [15:0] base_addr_ff,  base_addr_in;
   logic [15:0] base_count_ff, base_count_in;
   logic [15:0] cur_addr_ff,   cur_addr_in;
   logic [15:0] cur_count_ff,  cur_count_in;
   logic [15:0] offset_ff,     offset_in;

   logic [15:0] addr_put;
   logic [15:0] count_put;
   logic [31:0] offset_term;
   logic [31:0] xfer_addr;

   // byte flip-flop picks which half of the word takes the data
   assign addr_put  = op.hi ? {op.data, base_addr_ff[7:0]}  : {base_addr_ff[15:8], op.data};
   assign count_put = op.hi ? {op.data, base_count_ff[7:0]} : {base_count_ff[15:8], op.data};

   assign offset_term = mode_ff[dmac_pkg::MODE_DEC_BIT] ? (32'd0 - {16'd0, offset_ff})
                                                        : {16'd0, offset_ff};
   assign xfer_addr = (mem_base + {16'd0, base_addr_ff} + offset_term)
                    | {8'd0, page_ff, 16'd0};

   always_comb begin
      mode_in       = mode_ff;
      page_in       = page_ff;
      base_addr_in  = base_addr_ff;
      base_count_in = base_count_ff;
      cur_addr_in   = cur_addr_ff;
      cur_count_in  = cur_count_ff;
      offset_in     = offset_ff;
      priority if (op.clear) begin
         // mode survives a master clear
         page_in       = '0;
         base_addr_in  = '0;
         base_count_in = '0;
         cur_addr_in   = '0;
         cur_count_in  = dmac_pkg::COUNT_RESET;
         offset_in     = '0;
      end else if (op.wr_addr) begin
         base_addr_in = addr_put;
         cur_addr_in  = addr_put;
      end else if (op.wr_count) begin
         base_count_in = count_put;
         cur_count_in  = count_put;
         offset_in     = '0;
      end else if (op.wr_mode) begin
         mode_in = op.data;
      end else if (op.wr_page) begin
         page_in = op.data;
      end else if (op.step && dmac_pkg::mode_moves(mode_ff)) begin
         cur_addr_in  = xfer_addr[15:0];
         offset_in    = offset_ff + 16'd1;
         cur_count_in = cur_count_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         page_ff       <= '0;
         base_addr_ff  <= '0;
         base_count_ff <= '0;
         cur_addr_ff   <= '0;
         cur_count_ff  <= dmac_pkg::COUNT_RESET;
         offset_ff     <= '0;
      end else begin
         mode_ff       <= mode_in;
         page_ff       <= page_in;
         base_addr_ff  <= base_addr_in;
         base_count_ff <= base_count_in;
         cur_addr_ff   <= cur_addr_in;
         cur_count_ff  <= cur_count_in;
         offset_ff     <= offset_in;
      end
   end

   assign stat.mode       = mode_ff;
   assign stat.cur_addr   = cur_addr_ff;
   assign stat.cur_count  = cur_count_ff;
   assign stat.xfer_addr  = xfer_addr;
   assign stat.count_zero = (cur_count_ff == 16'd0);

endmodule
